// ===== design/fpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_pkg - flight phase detector shared types and constants
// Sample layout, output beat layout, phase and brake codes, register
// indexes and register reset values.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int DEF_RING_DEPTH = 32;

    localparam int SAMPLE_W = 112;
    localparam int OUT_W    = 136;

    // register indexes
    localparam logic [2:0] CFG_LAUNCH_THR  = 3'd0;
    localparam logic [2:0] CFG_BURNOUT_THR = 3'd1;
    localparam logic [2:0] CFG_BURNOUT_CNF = 3'd2;
    localparam logic [2:0] CFG_COAST_DLY   = 3'd3;
    localparam logic [2:0] CFG_APOGEE_CNF  = 3'd4;
    localparam logic [2:0] CFG_DEPLOY_STEP = 3'd5;

    // register reset values
    localparam logic [31:0] RST_LAUNCH_THR  = 32'd3541924;
    localparam logic [31:0] RST_BURNOUT_THR = 32'd393129;
    localparam logic [7:0]  RST_BURNOUT_CNF = 8'd5;
    localparam logic [15:0] RST_COAST_DLY   = 16'd1000;
    localparam logic [7:0]  RST_APOGEE_CNF  = 8'd5;
    localparam logic [15:0] RST_DEPLOY_STEP = 16'd200;

    typedef enum logic [2:0] {
        PH_PAD         = 3'd0,
        PH_BOOST       = 3'd1,
        PH_COAST_ONSET = 3'd2,
        PH_COAST       = 3'd3,
        PH_RECOVERY    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BRAKE_LOCKED    = 2'd0,
        BRAKE_PERMITTED = 2'd1,
        BRAKE_ACTIVE    = 2'd2
    } t_brake;

    // first field in the highest bits
    typedef struct packed {
        logic [31:0]        time_ms;
        logic signed [31:0] altitude;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } t_sample;

    typedef struct packed {
        logic [2:0]         pad;
        logic [31:0]        replay_time_ms;
        logic signed [31:0] replay_altitude;
        logic signed [15:0] replay_accel_z;
        logic signed [15:0] replay_accel_y;
        logic signed [15:0] replay_accel_x;
        logic [15:0]        brake_target;
        t_brake             brake_status;
        t_phase             phase;
    } t_out;

    function automatic t_brake brake_of(input t_phase ph);
        t_brake b;
        case (ph)
            PH_COAST_ONSET: b = BRAKE_PERMITTED;
            PH_COAST:       b = BRAKE_ACTIVE;
            default:        b = BRAKE_LOCKED;
        endcase
        return b;
    endfunction

endpackage

// ===== design/flight_phase_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flight_phase_detector_top - rocket flight phase detector
// Five-phase flight machine with a pre-launch sample ring replayed on launch.
// ----------------------------------------------------------------------------
// One sample is accepted at a time. A sample is processed on the
// shared squaring multiplier (three squares, registered, then accumulated),
// then in a decision state, then in a state that loads the status beat;
// a stalled output side holds the load. On the launching sample every ring
// entry is replayed before the status beat, each replayed beat taking a ring
// memory read, then an output load. The ring is a synchronous memory of
// RING_DEPTH samples.
// The next sample is taken while the last status beat still waits in the
// output register.
module flight_phase_detector_top
    import fpd_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    // sample input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], altitude[79:48],
    // time_ms[111:80]
    input  logic [SAMPLE_W-1:0] s_axis_tdata,
    // result output
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // phase[2:0], brake_status[4:3], brake_target[20:5], replay_accel_x[36:21],
    // replay_accel_y[52:37], replay_accel_z[68:53], replay_altitude[100:69],
    // replay_time_ms[132:101], zero[135:133]
    output logic [OUT_W-1:0]    m_axis_tdata,
    // is_replay
    output logic                m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_DECIDE,
        S_RD,
        S_RPL,
        S_STAT
    } t_state;

    // config registers
    logic [31:0] r_launch_thr;
    logic [31:0] r_burnout_thr;
    logic [7:0]  r_burnout_cnf;
    logic [15:0] r_coast_dly;
    logic [7:0]  r_apogee_cnf;
    logic [15:0] r_deploy_step;

    t_state      r_state;
    t_phase      r_phase;
    t_sample     r_in;
    logic [1:0]  r_step;
    logic [31:0] r_sq;
    logic [31:0] r_acc;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [7:0]  r_burn_run;
    logic [7:0]  r_desc_run;
    logic [31:0] r_coast_entry;
    logic signed [31:0] r_prior_alt;
    logic [AW-1:0] r_rd_idx;
    logic [FW-1:0] r_rpl_cnt;

    t_sample     r_ring [RING_DEPTH];
    t_sample     r_rd_data;

    logic        r_out_valid;
    t_out        r_out_data;
    logic        r_out_user;
    logic        r_out_last;

    logic               w_out_free;
    logic               w_out_load;
    logic               w_launch;
    logic signed [15:0] w_mul_op;
    logic signed [31:0] w_sq_prod;
    logic               w_ring_we;
    logic               w_ring_re;
    logic [AW-1:0]      n_head;
    logic [FW-1:0]      n_fill;
    logic [7:0]         n_burn_run;
    logic [7:0]         n_desc_run;
    logic [31:0]        w_elapsed;
    logic [AW-1:0]      n_rd_idx;
    t_out               w_stat;
    t_out               w_rpl;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = w_out_free && ((r_state == S_RPL) || (r_state == S_STAT));
    assign w_launch   = (r_phase == PH_PAD) && (r_acc >= r_launch_thr);

    // shared squaring unit, one axis per cycle
    always_comb begin
        case (r_step)
            2'd0:    w_mul_op = r_in.accel_x;
            2'd1:    w_mul_op = r_in.accel_y;
            default: w_mul_op = r_in.accel_z;
        endcase
    end
    assign w_sq_prod = w_mul_op * w_mul_op;

    assign n_head = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_fill = (r_fill < FW'(RING_DEPTH)) ? r_fill + 1'b1 : r_fill;
    assign n_rd_idx = (r_rd_idx == AW'(RING_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;

    assign n_burn_run = (r_acc > r_burnout_thr) ? 8'd0 :
                        (r_burn_run == 8'hFF) ? r_burn_run : r_burn_run + 8'd1;
    assign n_desc_run = (r_in.altitude >= r_prior_alt) ? 8'd0 :
                        (r_desc_run == 8'hFF) ? r_desc_run : r_desc_run + 8'd1;
    assign w_elapsed  = r_in.time_ms - r_coast_entry;

    assign w_ring_we = (r_state == S_DECIDE) && (r_phase == PH_PAD);
    assign w_ring_re = (r_state == S_RD);

    always_comb begin
        w_stat                 = '0;
        w_stat.phase           = r_phase;
        w_stat.brake_status    = brake_of(r_phase);
        w_stat.brake_target    = (r_phase == PH_COAST) ? r_deploy_step : 16'd0;
        w_rpl                  = w_stat;
        w_rpl.replay_accel_x   = r_rd_data.accel_x;
        w_rpl.replay_accel_y   = r_rd_data.accel_y;
        w_rpl.replay_accel_z   = r_rd_data.accel_z;
        w_rpl.replay_altitude  = r_rd_data.altitude;
        w_rpl.replay_time_ms   = r_rd_data.time_ms;
    end

    // pre-launch ring
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_head] <= r_in;
        end
        if (w_ring_re) begin
            r_rd_data <= r_ring[r_rd_idx];
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_thr  <= RST_LAUNCH_THR;
            r_burnout_thr <= RST_BURNOUT_THR;
            r_burnout_cnf <= RST_BURNOUT_CNF;
            r_coast_dly   <= RST_COAST_DLY;
            r_apogee_cnf  <= RST_APOGEE_CNF;
            r_deploy_step <= RST_DEPLOY_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAUNCH_THR:  r_launch_thr  <= i_cfg_data;
                CFG_BURNOUT_THR: r_burnout_thr <= i_cfg_data;
                CFG_BURNOUT_CNF: r_burnout_cnf <= i_cfg_data[7:0];
                CFG_COAST_DLY:   r_coast_dly   <= i_cfg_data[15:0];
                CFG_APOGEE_CNF:  r_apogee_cnf  <= i_cfg_data[7:0];
                CFG_DEPLOY_STEP: r_deploy_step <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // main sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_PAD;
            r_step        <= 2'd0;
            r_head        <= '0;
            r_fill        <= '0;
            r_burn_run    <= 8'd0;
            r_desc_run    <= 8'd0;
            r_coast_entry <= 32'd0;
            r_prior_alt   <= 32'sd0;
            r_rd_idx      <= '0;
            r_rpl_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in    <= t_sample'(s_axis_tdata);
                        r_step  <= 2'd0;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    // product registered, summed in the following cycle
                    r_sq   <= w_sq_prod;
                    r_acc  <= (r_step == 2'd0) ? 32'd0 : r_acc + r_sq;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= w_launch ? S_RD : S_STAT;
                    case (r_phase)
                        PH_PAD: begin
                            r_head <= n_head;
                            r_fill <= n_fill;
                            if (w_launch) begin
                                r_phase   <= PH_BOOST;
                                r_rpl_cnt <= n_fill;
                                r_rd_idx  <= (n_fill < FW'(RING_DEPTH)) ? '0 : n_head;
                            end
                        end
                        PH_BOOST: begin
                            r_burn_run <= n_burn_run;
                            if (n_burn_run >= r_burnout_cnf) begin
                                r_phase       <= PH_COAST_ONSET;
                                r_coast_entry <= r_in.time_ms;
                            end
                        end
                        PH_COAST_ONSET: begin
                            if (w_elapsed >= {16'd0, r_coast_dly}) begin
                                r_phase <= PH_COAST;
                            end
                        end
                        PH_COAST: begin
                            r_desc_run  <= n_desc_run;
                            r_prior_alt <= r_in.altitude;
                            if (n_desc_run >= r_apogee_cnf) begin
                                r_phase <= PH_RECOVERY;
                            end
                        end
                        default: ;
                    endcase
                end
                S_RD: begin
                    r_state <= S_RPL;
                end
                S_RPL: begin
                    if (w_out_free) begin
                        r_out_data  <= w_rpl;
                        r_out_user  <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_rd_idx    <= n_rd_idx;
                        r_rpl_cnt   <= r_rpl_cnt - 1'b1;
                        r_state     <= (r_rpl_cnt == FW'(1)) ? S_STAT : S_RD;
                    end
                end
                S_STAT: begin
                    if (w_out_free) begin
                        r_out_data  <= w_stat;
                        r_out_user  <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a beat is either a replayed sample or the closing status beat
    a_last_vs_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last != r_out_user))
        else $error("tlast and tuser disagree on beat kind");

    // replayed samples are only sent right after launch
    a_replay_in_boost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user) |-> (r_out_data.phase == PH_BOOST))
        else $error("replay beat outside boost");

    // flight phase only moves forward
    a_phase_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_phase >= $past(r_phase)))
        else $error("flight phase went backward");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(RING_DEPTH)) && (r_rpl_cnt <= FW'(RING_DEPTH)))
        else $error("ring fill or replay count out of range");

endmodule
